[src/mclp_pkg.sv]
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types and constants of the motor command line parser: byte codes,
// run modes, command classes and the queue entry between front and back.
// ----------------------------------------------------------------------------
package mclp_pkg;

  typedef logic [3:0] op_t;

  // Command classes decided by the front end.
  localparam op_t OP_STOP      = 4'd0;
  localparam op_t OP_OPHEX     = 4'd1;
  localparam op_t OP_OPDEC     = 4'd2;
  localparam op_t OP_INIT      = 4'd3;
  localparam op_t OP_UP        = 4'd4;
  localparam op_t OP_DUTY      = 4'd5;
  localparam op_t OP_NEWLINE   = 4'd6;
  localparam op_t OP_CLEAR     = 4'd7;
  localparam op_t OP_BACKSPACE = 4'd8;
  localparam op_t OP_STORE     = 4'd9;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_STOP  = 3'd0;
  localparam mode_t MODE_OPDEC = 3'd1;
  localparam mode_t MODE_OPHEX = 3'd2;
  localparam mode_t MODE_INIT  = 3'd3;
  localparam mode_t MODE_UP    = 3'd4;
  localparam mode_t MODE_DUTY  = 3'd5;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Number of hex digits on a target line (three 16-bit groups).
  localparam int HEX_DIGITS = 12;

  // Depth of the command queue; must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [31:0] count_zero;
    logic [31:0] count_one;
    logic [31:0] count_two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

endpackage

[src/mclp_in_if.sv]
// ----------------------------------------------------------------------------
// mclp_in_if
// Input channel: one received byte together with the three encoder counts.
// ----------------------------------------------------------------------------
interface mclp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] count_zero;
  logic [31:0] count_one;
  logic [31:0] count_two;

  modport source (output valid, output rx_byte, output count_zero,
                  output count_one, output count_two, input ready);
  modport sink   (input valid, input rx_byte, input count_zero,
                  input count_one, input count_two, output ready);
endinterface

[src/mclp_out_if.sv]
// ----------------------------------------------------------------------------
// mclp_out_if
// Result channel: run mode, targets, duties and the per-byte event pulses.
// ----------------------------------------------------------------------------
interface mclp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         run_mode;
  logic [31:0]        target_zero;
  logic [31:0]        target_one;
  logic [31:0]        target_two;
  logic signed [31:0] duty_zero;
  logic signed [31:0] duty_one;
  logic signed [31:0] duty_two;
  logic               controller_reset;
  logic               line_done;
  logic               line_error;

  modport source (output valid, output run_mode, output target_zero,
                  output target_one, output target_two, output duty_zero,
                  output duty_one, output duty_two, output controller_reset,
                  output line_done, output line_error, input ready);
  modport sink   (input valid, input run_mode, input target_zero,
                  input target_one, input target_two, input duty_zero,
                  input duty_one, input duty_two, input controller_reset,
                  input line_done, input line_error, output ready);
endinterface

[src/motor_command_line_parser_core.sv]
// ----------------------------------------------------------------------------
// motor_command_line_parser_core
// Command line parser for a three-motor controller fed by a serial receiver.
// ----------------------------------------------------------------------------
// Usage:
// Every byte on the cmd channel, together with the three encoder counts,
// yields exactly one transaction on the rsp channel carrying the run mode,
// the three targets, the three duties and the controller reset, line done
// and line error pulses for that byte.
// A front end classifies each byte and places it in a two-entry queue; the
// execution engine behind it owns the line store and all motor state.
// A plain byte or command letter passes through the queue and its result
// is registered in the engine. A newline in operation or duty mode walks
// the line store one byte per cycle and stops at the first malformed byte
// or at the closing CR; its result is registered when the walk ends.
// Throughput: one byte per cycle while rsp accepts, except parsed newlines.
// While rsp is stalled the engine holds, the queue fills and cmd.ready
// drops once two further bytes are waiting; nothing is lost.
// Reset (rst, synchronous) empties the queue and line, selects the stopped
// mode and clears targets and duties.
// ----------------------------------------------------------------------------
module motor_command_line_parser_core
  import mclp_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  mclp_in_if.sink    cmd,
  mclp_out_if.source rsp
);

  slot_t push;
  slot_t head;
  logic  full;
  logic  pop;

  mclp_front u_front (
    .cmd  (cmd),
    .full (full),
    .push (push)
  );

  mclp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  mclp_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

[src/mclp_front.sv]
// ----------------------------------------------------------------------------
// mclp_front
// Accepts received bytes and classifies each into a command class before it
// enters the command queue.
// ----------------------------------------------------------------------------
module mclp_front
  import mclp_pkg::*;
(
  mclp_in_if.sink cmd,
  input  logic    full,
  output slot_t   push
);

  op_t op;

  always_comb begin
    case (cmd.rx_byte)
      "s", "S", " ":     op = OP_STOP;
      "o", "O":          op = OP_OPHEX;
      "p", "P":          op = OP_OPDEC;
      "i", "I":          op = OP_INIT;
      "u", "U":          op = OP_UP;
      "k", "K":          op = OP_DUTY;
      CH_LF:             op = OP_NEWLINE;
      CH_ESC:            op = OP_CLEAR;
      CH_BS:             op = OP_BACKSPACE;
      default:           op = OP_STORE;
    endcase
  end

  assign cmd.ready              = !full;
  assign push.valid             = cmd.valid && !full;
  assign push.entry.op          = op;
  assign push.entry.data        = cmd.rx_byte;
  assign push.entry.count_zero  = cmd.count_zero;
  assign push.entry.count_one   = cmd.count_one;
  assign push.entry.count_two   = cmd.count_two;

endmodule

[src/mclp_queue.sv]
// ----------------------------------------------------------------------------
// mclp_queue
// Short first-in first-out queue of classified commands between the front
// end and the execution engine.
// ----------------------------------------------------------------------------
module mclp_queue
  import mclp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  slot_t push,
  input  logic  pop,
  output logic  full,
  output slot_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[src/mclp_back.sv]
// ----------------------------------------------------------------------------
// mclp_back
// Execution engine: owns the line store, run mode, targets and duties,
// carries out each command and walks the line store on a newline.
// ----------------------------------------------------------------------------
module mclp_back
  import mclp_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  slot_t       head,
  output logic        pop,
  mclp_out_if.source  rsp
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_WALK = 1'b1;

  function automatic logic is_dec(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_dec(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = is_dec(b) ? b[3:0] : (b[3:0] + 4'd9);
    return v;
  endfunction

  logic [7:0]    line_mem [LINE_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] next_pos;

  logic [0:0]    state;
  mode_t         mode;
  logic [LW-1:0] len;
  logic [31:0]   target [3];
  logic [31:0]   duty [3];
  logic          out_valid;
  logic          ctl_reset;
  logic          done;
  logic          err;

  logic [LW-1:0] pos;
  logic [47:0]   acc;
  logic [31:0]   num;
  logic [1:0]    motor;
  logic          neg;

  logic          out_free;
  logic          parse_mode;
  logic          len_ok;
  logic          start_walk;
  logic          finish_idle;
  logic          is_last;
  logic          w_hex;
  logic          w_fail;
  logic          w_pass;
  logic          w_neg;
  logic          w_dig;
  logic          walk_end;
  logic [31:0]   num_next;
  logic [31:0]   value;
  logic          do_store;

  assign out_free = !out_valid || rsp.ready;
  assign pop      = head.valid && out_free && (state == ST_IDLE);

  assign parse_mode = (mode == MODE_OPHEX) || (mode == MODE_OPDEC) || (mode == MODE_DUTY);
  assign len_ok     = (mode == MODE_OPHEX) ? (len == LW'(HEX_DIGITS + 1))
                                           : (len >= LW'(2));
  assign start_walk  = pop && (head.entry.op == OP_NEWLINE) && parse_mode && len_ok;
  assign finish_idle = pop && !start_walk;
  assign do_store    = pop && (head.entry.op == OP_STORE) && (len < LW'(LINE_DEPTH));

  // The read port runs one byte ahead of the position under evaluation.
  assign next_pos = pos + LW'(1);
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = '0;
    end else if (next_pos < LW'(LINE_DEPTH)) begin
      rd_addr = next_pos[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      line_mem[len[AW-1:0]] <= head.entry.data;
    end
    rd_data <= line_mem[rd_addr];
  end

  // Evaluation of the byte at pos during a walk.
  assign is_last  = (pos == len - LW'(1));
  assign w_hex    = (mode == MODE_OPHEX);
  assign num_next = {num[28:0], 3'b000} + {num[30:0], 1'b0} + {28'd0, rd_data[3:0]};
  assign value    = neg ? (32'd0 - num) : num;

  always_comb begin
    w_fail = 1'b0;
    w_pass = 1'b0;
    w_neg  = 1'b0;
    w_dig  = 1'b0;
    if (w_hex) begin
      if (is_last) begin
        w_pass = (rd_data == CH_CR);
        w_fail = !w_pass;
      end else begin
        w_dig  = is_hex(rd_data);
        w_fail = !w_dig;
      end
    end else if (pos == '0) begin
      w_fail = (rd_data < "0") || (rd_data > "2");
    end else if (is_last) begin
      w_pass = (rd_data == CH_CR);
      w_fail = !w_pass;
    end else begin
      w_neg  = (mode == MODE_DUTY) && (pos == LW'(1)) && (rd_data == CH_MINUS);
      w_dig  = !w_neg && is_dec(rd_data);
      w_fail = !w_neg && !w_dig;
    end
  end

  assign walk_end = (state == ST_WALK) && (w_fail || w_pass);

  always_ff @(posedge clk) begin
    if (start_walk) begin
      pos   <= '0;
      acc   <= '0;
      num   <= '0;
      neg   <= 1'b0;
      motor <= '0;
    end else if (state == ST_WALK) begin
      pos <= next_pos;
      if (w_hex && w_dig) begin
        acc <= {acc[43:0], hex_val(rd_data)};
      end
      if (!w_hex && (pos == '0)) begin
        motor <= rd_data[1:0];
      end
      if (w_neg) begin
        neg <= 1'b1;
      end
      if (!w_hex && w_dig) begin
        num <= num_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_STOP;
      len       <= '0;
      target[0] <= '0;
      target[1] <= '0;
      target[2] <= '0;
      duty[0]   <= '0;
      duty[1]   <= '0;
      duty[2]   <= '0;
      out_valid <= 1'b0;
      ctl_reset <= 1'b0;
      done      <= 1'b0;
      err       <= 1'b0;
    end else begin
      if (finish_idle || walk_end) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (finish_idle) begin
        ctl_reset <= (head.entry.op == OP_OPHEX) || (head.entry.op == OP_OPDEC);
        done      <= (head.entry.op == OP_NEWLINE);
        err       <= (head.entry.op == OP_NEWLINE) && parse_mode;
        case (head.entry.op)
          OP_STOP: begin
            mode <= MODE_STOP;
            len  <= '0;
          end
          OP_OPHEX, OP_OPDEC: begin
            target[0] <= head.entry.count_zero;
            target[1] <= head.entry.count_one;
            target[2] <= head.entry.count_two;
            mode      <= (head.entry.op == OP_OPHEX) ? MODE_OPHEX : MODE_OPDEC;
            len       <= '0;
          end
          OP_INIT: begin
            mode <= MODE_INIT;
            len  <= '0;
          end
          OP_UP: begin
            mode <= MODE_UP;
            len  <= '0;
          end
          OP_DUTY: begin
            duty[0] <= '0;
            duty[1] <= '0;
            duty[2] <= '0;
            mode    <= MODE_DUTY;
            len     <= '0;
          end
          OP_NEWLINE: begin
            // A line too short or too long for its mode cannot parse.
            len <= '0;
          end
          OP_CLEAR: begin
            len <= '0;
          end
          OP_BACKSPACE: begin
            if (len != '0) begin
              len <= len - LW'(1);
            end
          end
          OP_STORE: begin
            if (len < LW'(LINE_DEPTH)) begin
              len <= len + LW'(1);
            end
          end
          default: begin
          end
        endcase
      end else if (start_walk) begin
        state <= ST_WALK;
      end else if (walk_end) begin
        state     <= ST_IDLE;
        ctl_reset <= 1'b0;
        done      <= 1'b1;
        err       <= w_fail;
        len       <= '0;
        if (w_pass) begin
          if (w_hex) begin
            target[0] <= {16'd0, acc[47:32]};
            target[1] <= {16'd0, acc[31:16]};
            target[2] <= {16'd0, acc[15:0]};
          end else begin
            case (motor)
              2'd0: begin
                if (mode == MODE_DUTY) duty[0] <= value;
                else target[0] <= value;
              end
              2'd1: begin
                if (mode == MODE_DUTY) duty[1] <= value;
                else target[1] <= value;
              end
              2'd2: begin
                if (mode == MODE_DUTY) duty[2] <= value;
                else target[2] <= value;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // State only changes when a new result is loaded, so the live registers
  // form the result payload.
  assign rsp.valid            = out_valid;
  assign rsp.run_mode         = mode;
  assign rsp.target_zero      = target[0];
  assign rsp.target_one       = target[1];
  assign rsp.target_two       = target[2];
  assign rsp.duty_zero        = $signed(duty[0]);
  assign rsp.duty_one         = $signed(duty[1]);
  assign rsp.duty_two         = $signed(duty[2]);
  assign rsp.controller_reset = ctl_reset;
  assign rsp.line_done        = done;
  assign rsp.line_error       = err;

endmodule

[test/mclp_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_result_checker
// Watches both channels of the command line parser. Every accepted byte is
// run through a behavioural copy of the parser, and the status it predicts
// is queued; every result transaction is compared field by field with the
// oldest queued status. Mismatches and the number of outstanding statuses
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module mclp_result_checker
  import mclp_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  mclp_in_if   cmd,
  mclp_out_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    mode_t       run_mode;
    logic [31:0] target_zero;
    logic [31:0] target_one;
    logic [31:0] target_two;
    logic [31:0] duty_zero;
    logic [31:0] duty_one;
    logic [31:0] duty_two;
    logic        controller_reset;
    logic        line_done;
    logic        line_error;
  } status_t;

  logic [7:0]  line_buf [LINE_DEPTH];
  int          line_len;
  mode_t       mode;
  logic [31:0] targets [3];
  logic [31:0] duties [3];
  status_t     status_q [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // The line as the parser sees it: stored bytes, then the newline, then zeros.
  function automatic logic [7:0] line_char(int pos);
    if (pos < line_len && pos < LINE_DEPTH) return line_buf[pos];
    if (pos == line_len) return CH_LF;
    return 8'h00;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex_digit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic bit parse_hex_line();
    logic [15:0] group;
    int p;
    int k;
    for (p = 0; p < HEX_DIGITS; p++)
      if (!is_hex_digit(line_char(p))) return 1'b0;
    if (line_char(HEX_DIGITS) != CH_CR || line_char(HEX_DIGITS + 1) != CH_LF) return 1'b0;
    for (k = 0; k < 3; k++) begin
      group = '0;
      for (p = 0; p < 4; p++) group = {group[11:0], hex_value(line_char(k * 4 + p))};
      targets[k] = {16'h0000, group};
    end
    return 1'b1;
  endfunction

  // Motor digit, an optional minus where allowed, decimal digits, CR, LF.
  function automatic bit parse_motor_line(input bit allow_minus, output int motor,
                                          output logic [31:0] value);
    logic [7:0]  m;
    logic [31:0] num;
    int          pos;
    bit          neg;
    m   = line_char(0);
    pos = 1;
    num = '0;
    neg = 1'b0;
    if (m < "0" || m > "2") return 1'b0;
    if (allow_minus && line_char(1) == CH_MINUS) begin
      neg = 1'b1;
      pos = 2;
    end
    while (is_digit(line_char(pos))) begin
      num = num * 32'd10 + {24'h0, line_char(pos) - 8'h30};
      pos++;
    end
    if (line_char(pos) != CH_CR || line_char(pos + 1) != CH_LF) return 1'b0;
    motor = m - "0";
    value = neg ? (32'd0 - num) : num;
    return 1'b1;
  endfunction

  function automatic status_t apply_byte(logic [7:0] c, logic [31:0] c0, logic [31:0] c1,
                                         logic [31:0] c2);
    status_t     s;
    int          motor;
    logic [31:0] value;
    logic        reset_pulse;
    logic        done;
    logic        err;
    reset_pulse = 1'b0;
    done        = 1'b0;
    err         = 1'b0;
    case (c)
      "s", "S", " ": begin
        mode     = MODE_STOP;
        line_len = 0;
      end
      "o", "O", "p", "P": begin
        targets[0]  = c0;
        targets[1]  = c1;
        targets[2]  = c2;
        mode        = (c == "o" || c == "O") ? MODE_OPHEX : MODE_OPDEC;
        reset_pulse = 1'b1;
        line_len    = 0;
      end
      "i", "I": begin
        mode     = MODE_INIT;
        line_len = 0;
      end
      "u", "U": begin
        mode     = MODE_UP;
        line_len = 0;
      end
      "k", "K": begin
        duties[0] = '0;
        duties[1] = '0;
        duties[2] = '0;
        mode      = MODE_DUTY;
        line_len  = 0;
      end
      CH_LF: begin
        done = 1'b1;
        if (mode == MODE_OPHEX) begin
          err = !parse_hex_line();
        end else if (mode == MODE_OPDEC) begin
          if (parse_motor_line(1'b0, motor, value)) targets[motor] = value;
          else err = 1'b1;
        end else if (mode == MODE_DUTY) begin
          if (parse_motor_line(1'b1, motor, value)) duties[motor] = value;
          else err = 1'b1;
        end
        line_len = 0;
      end
      CH_ESC: line_len = 0;
      CH_BS: begin
        if (line_len > 0) line_len--;
      end
      default: begin
        // A full store drops the byte.
        if (line_len < LINE_DEPTH) begin
          line_buf[line_len] = c;
          line_len++;
        end
      end
    endcase
    s.run_mode         = mode;
    s.target_zero      = targets[0];
    s.target_one       = targets[1];
    s.target_two       = targets[2];
    s.duty_zero        = duties[0];
    s.duty_one         = duties[1];
    s.duty_two         = duties[2];
    s.controller_reset = reset_pulse;
    s.line_done        = done;
    s.line_error       = err;
    return s;
  endfunction

  always @(posedge clk) begin
    status_t want;
    int k;
    if (rst) begin
      mismatches = 0;
      line_len   = 0;
      mode       = MODE_STOP;
      for (k = 0; k < 3; k++) begin
        targets[k] = '0;
        duties[k]  = '0;
      end
      status_q.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        status_q.push_back(apply_byte(cmd.rx_byte, cmd.count_zero, cmd.count_one,
                                      cmd.count_two));
      if (rsp.valid && rsp.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing expected, run_mode", {29'h0, rsp.run_mode},
                          32'h0);
        end else begin
          want = status_q.pop_front();
          if (rsp.run_mode !== want.run_mode)
            report_mismatch("run_mode", {29'h0, rsp.run_mode}, {29'h0, want.run_mode});
          if (rsp.target_zero !== want.target_zero)
            report_mismatch("target_zero", rsp.target_zero, want.target_zero);
          if (rsp.target_one !== want.target_one)
            report_mismatch("target_one", rsp.target_one, want.target_one);
          if (rsp.target_two !== want.target_two)
            report_mismatch("target_two", rsp.target_two, want.target_two);
          if (rsp.duty_zero !== want.duty_zero)
            report_mismatch("duty_zero", rsp.duty_zero, want.duty_zero);
          if (rsp.duty_one !== want.duty_one)
            report_mismatch("duty_one", rsp.duty_one, want.duty_one);
          if (rsp.duty_two !== want.duty_two)
            report_mismatch("duty_two", rsp.duty_two, want.duty_two);
          if (rsp.controller_reset !== want.controller_reset)
            report_mismatch("controller_reset", {31'h0, rsp.controller_reset},
                            {31'h0, want.controller_reset});
          if (rsp.line_done !== want.line_done)
            report_mismatch("line_done", {31'h0, rsp.line_done}, {31'h0, want.line_done});
          if (rsp.line_error !== want.line_error)
            report_mismatch("line_error", {31'h0, rsp.line_error}, {31'h0, want.line_error});
        end
      end
    end
    outstanding <= status_q.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the motor command line parser. A short directed sequence
// touches every command, the hex, decimal and duty lines, malformed lines
// and backspace on an empty line; random sessions of well-formed lines with
// some noise, broken lines and overflowing lines follow, under three idling
// patterns on the two channels. The checker beside the block does all the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import mclp_pkg::*;

  localparam int LINE_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   sent_items  = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  mclp_in_if  cmd ();
  mclp_out_if rsp ();

  motor_command_line_parser_core #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  mclp_result_checker #(.LINE_DEPTH(LINE_DEPTH)) result_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Encoder counts lean towards their extremes now and then.
  function automatic logic [31:0] any_count();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [7:0] b, logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.rx_byte    <= b;
    cmd.count_zero <= c0;
    cmd.count_one  <= c1;
    cmd.count_two  <= c2;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(b, any_count(), any_count(), any_count());
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the input back until every predicted status has been seen.
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic hex_line();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        repeat ($urandom_range(0, 14)) send_byte(pick("0123456789abcdefABCDEF"));
        if ($urandom_range(1)) send_byte(CH_CR);
      end
      1: begin
        repeat (5) send_byte(pick("0123456789abcdefABCDEF"));
        send_byte(pick("gxz#0F"));
        send_byte(CH_BS);
        repeat (7) send_byte(pick("0123456789abcdefABCDEF"));
        send_byte(CH_CR);
      end
      2: begin
        repeat ($urandom_range(1, 8)) send_byte(pick("0123456789abcdefABCDEF"));
        send_byte(CH_ESC);
        repeat (12) send_byte(pick("0123456789abcdefABCDEF"));
        send_byte(CH_CR);
      end
      default: begin
        repeat (12) send_byte(pick("0123456789abcdefABCDEF"));
        send_byte(CH_CR);
      end
    endcase
    send_byte(CH_LF);
  endtask

  task automatic motor_line(bit duty);
    int kind;
    int digits;
    kind   = $urandom_range(9);
    digits = ($urandom_range(4) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 10);
    if (kind == 0) send_byte(pick("0123456789x/"));
    else send_byte(pick("012"));
    if ($urandom_range(1) && (duty || kind == 4)) send_byte(CH_MINUS);
    repeat (digits) send_byte(pick("0123456789"));
    if (kind == 1) send_byte(pick("x#.+-"));
    if (kind != 2) send_byte(CH_CR);
    if (kind == 3) begin
      send_byte(CH_BS);
      send_byte(CH_CR);
    end
    send_byte(CH_LF);
  endtask

  task automatic fill_line();
    repeat (LINE_DEPTH + $urandom_range(1, 8)) send_byte(pick("0123456789abcdefxyz#"));
    if ($urandom_range(1)) repeat ($urandom_range(1, 3)) send_byte(CH_BS);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic run_sessions(int quota);
    int stop_at;
    int pct;
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      pct = $urandom_range(99);
      if (pct < 30) begin
        send_byte(pick("oO"));
        repeat ($urandom_range(1, 4)) hex_line();
      end else if (pct < 55) begin
        send_byte(pick("pP"));
        repeat ($urandom_range(1, 4)) motor_line(1'b0);
      end else if (pct < 80) begin
        send_byte(pick("kK"));
        repeat ($urandom_range(1, 4)) motor_line(1'b1);
      end else if (pct < 88) begin
        send_byte(pick("iIuUsS "));
        repeat ($urandom_range(0, 8)) send_byte(pick("0123456789abcxyz#\r-"));
        send_byte(CH_LF);
      end else if (pct < 96) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(3) == 0) send_byte(pick("\n\r\033\010"));
          else send_byte(8'($urandom_range(255)));
        end
      end else begin
        fill_line();
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.rx_byte    = '0;
    cmd.count_zero = '0;
    cmd.count_one  = '0;
    cmd.count_two  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 36;
    rx_idle_pct = 55;

    // Directed sequence.
    send_byte(CH_BS);
    send_item("o", '1, '1, '1);
    send_text("FfFf00009aBc");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_item("P", '0, '0, '0);
    send_byte(CH_LF);
    send_byte("K");
    send_text("2-5");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte("u");
    send_byte(CH_LF);
    send_byte("I");
    send_byte(CH_ESC);
    send_byte(" ");

    // An overflowing line in decimal mode, then the random sessions.
    send_byte("p");
    fill_line();
    run_sessions(90);
    drain();

    tx_idle_pct = 55;
    rx_idle_pct = 36;
    run_sessions(90);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_sessions(90);
    drain();

    repeat (LINE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
